// ===== src/ilbcf_pkg.sv =====
// Package for the iso-level boundary cell finder.
// Register map codes, field widths and default grid limits.
// No dependencies.
package ilbcf_pkg;

  localparam int DEF_MAX_DIM_X    = 256;
  localparam int DEF_MAX_DIM_Y    = 64;
  localparam int DEF_MAX_DIM_Z    = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int THRESH_W = 16;
  localparam int DIM_X_W  = 9;
  localparam int DIM_Y_W  = 7;
  localparam int DIM_Z_W  = 7;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIM_X     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIM_Y     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIM_Z     = 2'd3;

  localparam logic [THRESH_W-1:0] THRESH_RST = '0;
  localparam logic [DIM_X_W-1:0]  DIM_X_RST  = 9'd2;
  localparam logic [DIM_Y_W-1:0]  DIM_Y_RST  = 7'd2;
  localparam logic [DIM_Z_W-1:0]  DIM_Z_RST  = 7'd2;

endpackage

// ===== src/iso_level_boundary_cell_finder.sv =====
// Iso-level boundary cell finder: thresholds a raster-ordered 3-D grid and
// reports cells whose corners straddle the threshold. Depends on ilbcf_pkg.
// A result passes through the stage 1 registers and then the output register.
// Throughput: one sample per cycle while the output is not stalled, set by one
// read and one write of the plane store and the row store per sample.
// Reset: control, position and registers clear at once; the stores are not
// cleared and need no clearing pass.
module iso_level_boundary_cell_finder
  import ilbcf_pkg::*;
#(
  parameter int MAX_DIM_X    = DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y    = DEF_MAX_DIM_Y,
  parameter int MAX_DIM_Z    = DEF_MAX_DIM_Z,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int XW    = $clog2(MAX_DIM_X),
  localparam int YW    = $clog2(MAX_DIM_Y),
  localparam int ZW    = $clog2(MAX_DIM_Z),
  localparam int IN_TW  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W  = XW + YW + ZW,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TW-1:0]      s_axis_tdata,  // sample_value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_TW-1:0]     m_axis_tdata,  // cell_x, cell_y, cell_z
  output logic                  m_axis_tuser,  // is_boundary
  output logic                  m_axis_tlast
);

  localparam int DXW = ($clog2(MAX_DIM_X + 1) > DIM_X_W) ? $clog2(MAX_DIM_X + 1) : DIM_X_W;
  localparam int DYW = ($clog2(MAX_DIM_Y + 1) > DIM_Y_W) ? $clog2(MAX_DIM_Y + 1) : DIM_Y_W;
  localparam int DZW = ($clog2(MAX_DIM_Z + 1) > DIM_Z_W) ? $clog2(MAX_DIM_Z + 1) : DIM_Z_W;
  localparam int TW  = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
  localparam int PAW = YW + ZW;
  localparam int PLANE_DEPTH = 2 ** PAW;

  // configuration registers
  logic [THRESH_W-1:0] thr_q;
  logic [DIM_X_W-1:0]  dim_x_q;
  logic [DIM_Y_W-1:0]  dim_y_q;
  logic [DIM_Z_W-1:0]  dim_z_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_wr, dim_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign dim_wr  = cfg_wr && (reg_idx != REG_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESH_RST;
      dim_x_q <= DIM_X_RST;
      dim_y_q <= DIM_Y_RST;
      dim_z_q <= DIM_Z_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: thr_q   <= pwdata[THRESH_W-1:0];
        REG_DIM_X:     dim_x_q <= pwdata[DIM_X_W-1:0];
        REG_DIM_Y:     dim_y_q <= pwdata[DIM_Y_W-1:0];
        REG_DIM_Z:     dim_z_q <= pwdata[DIM_Z_W-1:0];
        default:       thr_q   <= thr_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DATA_W'(thr_q);
      REG_DIM_X:     prdata = APB_DATA_W'(dim_x_q);
      REG_DIM_Y:     prdata = APB_DATA_W'(dim_y_q);
      REG_DIM_Z:     prdata = APB_DATA_W'(dim_z_q);
      default:       prdata = '0;
    endcase
  end

  // effective dimensions, clamped
  logic [DXW-1:0] dx_ext, dx_eff, dx_m1;
  logic [DYW-1:0] dy_ext, dy_eff, dy_m1;
  logic [DZW-1:0] dz_ext, dz_eff, dz_m1;

  assign dx_ext = DXW'(dim_x_q);
  assign dy_ext = DYW'(dim_y_q);
  assign dz_ext = DZW'(dim_z_q);
  assign dx_eff = (dx_ext < DXW'(2)) ? DXW'(2) :
                  (dx_ext > DXW'(MAX_DIM_X)) ? DXW'(MAX_DIM_X) : dx_ext;
  assign dy_eff = (dy_ext < DYW'(2)) ? DYW'(2) :
                  (dy_ext > DYW'(MAX_DIM_Y)) ? DYW'(MAX_DIM_Y) : dy_ext;
  assign dz_eff = (dz_ext < DZW'(2)) ? DZW'(2) :
                  (dz_ext > DZW'(MAX_DIM_Z)) ? DZW'(MAX_DIM_Z) : dz_ext;
  assign dx_m1 = dx_eff - DXW'(1);
  assign dy_m1 = dy_eff - DYW'(1);
  assign dz_m1 = dz_eff - DZW'(1);

  // stage 0: position, compare, store reads
  logic [XW-1:0] pos_x_q;
  logic [YW-1:0] pos_y_q;
  logic [ZW-1:0] pos_z_q;
  logic x_end, y_end, z_end, s_acc;
  logic [TW-1:0] thr_ext;
  logic signed [SAMPLE_WIDTH-1:0] smp, thr_s;
  logic above;

  assign x_end = (DXW'(pos_x_q) == dx_m1);
  assign y_end = (DYW'(pos_y_q) == dy_m1);
  assign z_end = (DZW'(pos_z_q) == dz_m1);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  assign thr_ext = TW'(thr_q);
  assign thr_s   = thr_ext[SAMPLE_WIDTH-1:0];
  assign smp     = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign above   = (smp > thr_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (dim_wr) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (s_acc) begin
      if (z_end) begin
        pos_z_q <= '0;
        if (y_end) begin
          pos_y_q <= '0;
          pos_x_q <= x_end ? '0 : pos_x_q + XW'(1);
        end else begin
          pos_y_q <= pos_y_q + YW'(1);
        end
      end else begin
        pos_z_q <= pos_z_q + ZW'(1);
      end
    end
  end

  // stage 1 registers
  logic           s1_valid_q, s1_fire;
  logic           s1_bit_q, s1_inner_q, s1_last_q;
  logic [PAW-1:0] s1_paddr_q;
  logic [ZW-1:0]  s1_z_q;
  logic [XW-1:0]  s1_cx_q;
  logic [YW-1:0]  s1_cy_q;
  logic [ZW-1:0]  s1_cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_bit_q   <= above;
      s1_inner_q <= (pos_x_q != '0) && (pos_y_q != '0) && (pos_z_q != '0);
      s1_last_q  <= x_end && y_end && z_end;
      s1_paddr_q <= {pos_y_q, pos_z_q};
      s1_z_q     <= pos_z_q;
      s1_cx_q    <= pos_x_q - XW'(1);
      s1_cy_q    <= pos_y_q - YW'(1);
      s1_cz_q    <= pos_z_q - ZW'(1);
    end
  end

  // stores: plane bits of the previous x-plane, bit pairs of the previous y-row
  logic       plane_mem [PLANE_DEPTH];
  logic [1:0] row_mem   [MAX_DIM_Z];
  logic       plane_rd_q;
  logic [1:0] row_rd_q;
  logic [1:0] here;

  assign here = {s1_bit_q, plane_rd_q};

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      plane_mem[s1_paddr_q] <= s1_bit_q;
    end
    if (s_acc) begin
      plane_rd_q <= plane_mem[{pos_y_q, pos_z_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      row_mem[s1_z_q] <= here;
    end
    if (s_acc) begin
      row_rd_q <= row_mem[pos_z_q];
    end
  end

  // pairs of the previous transaction give the z-1 corners
  logic [1:0] here_prev_q, up_prev_q;
  logic [7:0] corners;
  logic       bnd, has_res;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      here_prev_q <= here;
      up_prev_q   <= row_rd_q;
    end
  end

  assign corners = {here, row_rd_q, up_prev_q, here_prev_q};
  assign bnd     = s1_inner_q && (|corners) && !(&corners);
  assign has_res = bnd || s1_last_q;

  // output register
  logic          out_valid_q, out_bnd_q, out_last_q;
  logic [XW-1:0] out_cx_q;
  logic [YW-1:0] out_cy_q;
  logic [ZW-1:0] out_cz_q;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_res) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_res) begin
      out_bnd_q  <= bnd;
      out_last_q <= s1_last_q;
      out_cx_q   <= bnd ? s1_cx_q : '0;
      out_cy_q   <= bnd ? s1_cy_q : '0;
      out_cz_q   <= bnd ? s1_cz_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_cz_q, out_cy_q, out_cx_q});
  assign m_axis_tuser  = out_bnd_q;
  assign m_axis_tlast  = out_last_q;

  a_s1_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> s1_valid_q)
    else $error("stage 1 not loaded after sample transaction");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_paddr_q))
    else $error("stalled stage 1 lost its item");

  a_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && x_end && y_end && z_end |=>
      pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0)
    else $error("position did not wrap after final sample");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    DZW'(pos_z_q) <= dz_m1 && DYW'(pos_y_q) <= dy_m1 && DXW'(pos_x_q) <= dx_m1)
    else $error("position outside grid");

  a_no_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !(s1_fire))
    else $error("result register overwritten while held");

endmodule
